>>> hw/rtl/lzd_pkg.sv
// Shared constants and types of the LZ77 byte decompressor.
package lzd_pkg;

    localparam int LZD_WINDOW_DEPTH = 4096;

    localparam logic [7:0] LZD_TYPE_BYTE     = 8'h10;
    localparam logic [4:0] LZD_MIN_MATCH     = 5'd3;
    localparam logic [3:0] LZD_TOKENS_PER_FL = 4'd8;

    // Depth of the result queue ahead of the master side.
    localparam int LZD_FIFO_DEPTH = 4;
    localparam int LZD_FIFO_AW    = $clog2(LZD_FIFO_DEPTH);
    localparam int LZD_FIFO_CW    = $clog2(LZD_FIFO_DEPTH + 1);

    typedef enum logic [8:0] {
        ST_TYPE   = 9'b000000001,
        ST_SIZE0  = 9'b000000010,
        ST_SIZE1  = 9'b000000100,
        ST_SIZE2  = 9'b000001000,
        ST_FLAG   = 9'b000010000,
        ST_TOKEN  = 9'b000100000,
        ST_MATCH2 = 9'b001000000,
        ST_IDLE   = 9'b010000000,
        ST_COPY   = 9'b100000000
    } t_state;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       stream_done;
        logic       bad_header;
    } t_result;

endpackage

>>> hw/rtl/lzd_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module lzd_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 4096,
    parameter int AW     = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_q;

    // Read-first: a read and a write of the same entry return the old data.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

>>> hw/rtl/lz77_byte_decompressor_unit.sv
// Top level of the LZ10-style LZ77 byte-stream decompressor.
//
// The block takes one compressed byte per input beat and delivers the
// decompressed bytes one per output beat. A stream opens with a type byte
// (0x10) and a 24-bit little-endian output size; a beat with the start flag
// set always begins a new header. Header, flag, literal and match token bytes
// are taken at one per clock cycle while the result queue has room. A match
// of length L (3 to 18) holds the input side while its bytes are read, one
// per cycle while the queue has room, from the 4096-byte history ring and
// sent on; the single read port of that ring sets this rate. Results pass
// through a four-deep queue, so the input side keeps moving while the
// master side stalls briefly. A bad type byte gives a single error beat and
// everything up to the next start flag is ignored, as is everything after
// the declared size has been produced. The ring reads as zeros after reset:
// a fill tracker marks which entries have been written, so no clearing
// pass is needed and the block is ready as soon as reset is released.
module lz77_byte_decompressor_unit
    import lzd_pkg::*;
#(
    parameter int WINDOW_DEPTH = LZD_WINDOW_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Slave side: compressed bytes.
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,  // [7:0] in_byte
    input  logic [0:0] i_s_axis_tuser,  // [0] stream_start
    // Master side: decompressed bytes.
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,  // [7:0] out_byte
    output logic       o_m_axis_tlast,  // run_last
    output logic [1:0] o_m_axis_tuser   // [0] stream_done, [1] bad_header
);

    localparam int AW = $clog2(WINDOW_DEPTH);

    // Parser and copy engine state.
    t_state      r_state,      n_state;
    logic [23:0] r_size,       n_size;
    logic [7:0]  r_flags,      n_flags;
    logic [3:0]  r_flags_left, n_flags_left;
    logic [7:0]  r_hi,         n_hi;
    logic [AW-1:0] r_wp,       n_wp;
    logic [AW-1:0] r_src,      n_src;
    logic [4:0]  r_cnt,        n_cnt;
    logic        r_wrapped,    n_wrapped;

    // Fetch stage: one result on its way from the ring into the queue.
    logic          r_s1_valid,    n_s1_valid;
    logic          r_s1_we,       n_s1_we;
    logic          r_s1_from_ram, n_s1_from_ram;
    logic [AW-1:0] r_s1_waddr,    n_s1_waddr;
    logic [7:0]    r_s1_byte,     n_s1_byte;
    logic          r_s1_last,     n_s1_last;
    logic          r_s1_done,     n_s1_done;
    logic          r_s1_bad,      n_s1_bad;

    // Result queue.
    t_result                r_fifo [LZD_FIFO_DEPTH];
    logic [LZD_FIFO_AW-1:0] r_fifo_wr, r_fifo_rd;
    logic [LZD_FIFO_CW-1:0] r_fifo_cnt;

    logic       accept;
    logic       credit;
    logic       pop;
    logic       fwd_hit;
    logic       written;
    logic [7:0] ram_q;
    logic [7:0] emit_byte;
    t_state     phase;
    t_result    push_item;

    // The queue plus the byte in flight must never exceed the queue depth.
    assign credit = (r_fifo_cnt + LZD_FIFO_CW'(r_s1_valid))
                    < LZD_FIFO_CW'(LZD_FIFO_DEPTH);
    assign o_s_axis_tready = (r_state != ST_COPY) && credit;
    assign accept  = i_s_axis_tvalid && o_s_axis_tready;
    assign pop     = o_m_axis_tvalid && i_m_axis_tready;

    // A copied byte comes from the ring unless its value was settled at issue.
    assign emit_byte = r_s1_from_ram ? ram_q : r_s1_byte;

    // The byte being written this cycle is not yet visible to a read of the
    // same entry, so such a read takes the write data instead.
    assign fwd_hit = r_s1_valid && r_s1_we && (r_src == r_s1_waddr);
    // Entries below the write pointer, or all once it has wrapped, hold data.
    assign written = r_wrapped || (r_src < r_wp);

    assign phase = i_s_axis_tuser[0] ? ST_TYPE : r_state;

    always_comb begin
        n_state       = r_state;
        n_size        = r_size;
        n_flags       = r_flags;
        n_flags_left  = r_flags_left;
        n_hi          = r_hi;
        n_wp          = r_wp;
        n_src         = r_src;
        n_cnt         = r_cnt;
        n_wrapped     = r_wrapped;
        n_s1_valid    = 1'b0;
        n_s1_we       = 1'b0;
        n_s1_from_ram = 1'b0;
        n_s1_waddr    = r_wp;
        n_s1_byte     = 8'h00;
        n_s1_last     = 1'b1;
        n_s1_done     = 1'b0;
        n_s1_bad      = 1'b0;

        if (accept) begin
            case (phase)
                ST_TYPE: begin
                    if (i_s_axis_tdata != LZD_TYPE_BYTE) begin
                        n_s1_valid = 1'b1;
                        n_s1_bad   = 1'b1;
                        n_state    = ST_IDLE;
                    end else begin
                        n_state = ST_SIZE0;
                    end
                end
                ST_SIZE0: begin
                    n_size  = {16'h0000, i_s_axis_tdata};
                    n_state = ST_SIZE1;
                end
                ST_SIZE1: begin
                    n_size  = {8'h00, i_s_axis_tdata, r_size[7:0]};
                    n_state = ST_SIZE2;
                end
                ST_SIZE2: begin
                    n_size = {i_s_axis_tdata, r_size[15:0]};
                    // An empty stream produces nothing at all.
                    n_state = (n_size == 24'd0) ? ST_IDLE : ST_FLAG;
                end
                ST_FLAG: begin
                    n_flags      = i_s_axis_tdata;
                    n_flags_left = LZD_TOKENS_PER_FL;
                    n_state      = ST_TOKEN;
                end
                ST_TOKEN: begin
                    if (r_flags[7]) begin
                        n_hi    = i_s_axis_tdata;
                        n_state = ST_MATCH2;
                    end else begin
                        n_s1_valid = 1'b1;
                        n_s1_we    = 1'b1;
                        n_s1_byte  = i_s_axis_tdata;
                        n_s1_done  = (r_size == 24'd1);
                        n_size     = r_size - 24'd1;
                        n_wp       = r_wp + AW'(1);
                        if (r_wp == {AW{1'b1}}) begin
                            n_wrapped = 1'b1;
                        end
                        if (n_s1_done) begin
                            n_state = ST_IDLE;
                        end else begin
                            n_flags      = {r_flags[6:0], 1'b0};
                            n_flags_left = r_flags_left - 4'd1;
                            n_state      = (r_flags_left == 4'd1) ? ST_FLAG : ST_TOKEN;
                        end
                    end
                end
                ST_MATCH2: begin
                    // Distance is the 12-bit field plus one, taken back from
                    // the write pointer around the ring.
                    n_src   = r_wp - AW'({r_hi[3:0], i_s_axis_tdata}) - AW'(1);
                    n_cnt   = {1'b0, r_hi[7:4]} + LZD_MIN_MATCH;
                    n_state = ST_COPY;
                end
                default: begin
                    // Idle: the byte is dropped.
                end
            endcase
        end else if ((r_state == ST_COPY) && credit) begin
            n_s1_valid    = 1'b1;
            n_s1_we       = 1'b1;
            n_s1_from_ram = written && !fwd_hit;
            n_s1_byte     = fwd_hit ? emit_byte : 8'h00;
            n_s1_done     = (r_size == 24'd1);
            n_s1_last     = (r_cnt == 5'd1) || n_s1_done;
            n_size        = r_size - 24'd1;
            n_src         = r_src + AW'(1);
            n_cnt         = r_cnt - 5'd1;
            n_wp          = r_wp + AW'(1);
            if (r_wp == {AW{1'b1}}) begin
                n_wrapped = 1'b1;
            end
            if (n_s1_done) begin
                n_state = ST_IDLE;
            end else if (r_cnt == 5'd1) begin
                n_flags      = {r_flags[6:0], 1'b0};
                n_flags_left = r_flags_left - 4'd1;
                n_state      = (r_flags_left == 4'd1) ? ST_FLAG : ST_TOKEN;
            end
        end
    end

    lzd_ram #(
        .DATA_W (8),
        .DEPTH  (WINDOW_DEPTH),
        .AW     (AW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid && r_s1_we),
        .i_waddr (r_s1_waddr),
        .i_wdata (emit_byte),
        .i_raddr (r_src),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_TYPE;
            r_size       <= '0;
            r_flags      <= '0;
            r_flags_left <= '0;
            r_hi         <= '0;
            r_wp         <= '0;
            r_src        <= '0;
            r_cnt        <= '0;
            r_wrapped    <= 1'b0;
            r_s1_valid   <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_size       <= n_size;
            r_flags      <= n_flags;
            r_flags_left <= n_flags_left;
            r_hi         <= n_hi;
            r_wp         <= n_wp;
            r_src        <= n_src;
            r_cnt        <= n_cnt;
            r_wrapped    <= n_wrapped;
            r_s1_valid   <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_we       <= n_s1_we;
        r_s1_from_ram <= n_s1_from_ram;
        r_s1_waddr    <= n_s1_waddr;
        r_s1_byte     <= n_s1_byte;
        r_s1_last     <= n_s1_last;
        r_s1_done     <= n_s1_done;
        r_s1_bad      <= n_s1_bad;
    end

    // Result queue: the fetch stage pushes, the master side pops.
    assign push_item = '{out_byte:    emit_byte,
                         run_last:    r_s1_last,
                         stream_done: r_s1_done,
                         bad_header:  r_s1_bad};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fifo_wr  <= '0;
            r_fifo_rd  <= '0;
            r_fifo_cnt <= '0;
        end else begin
            if (r_s1_valid) begin
                r_fifo_wr <= r_fifo_wr + LZD_FIFO_AW'(1);
            end
            if (pop) begin
                r_fifo_rd <= r_fifo_rd + LZD_FIFO_AW'(1);
            end
            r_fifo_cnt <= r_fifo_cnt + LZD_FIFO_CW'(r_s1_valid) - LZD_FIFO_CW'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_fifo[r_fifo_wr] <= push_item;
        end
    end

    assign o_m_axis_tvalid   = (r_fifo_cnt != '0);
    assign o_m_axis_tdata    = r_fifo[r_fifo_rd].out_byte;
    assign o_m_axis_tlast    = r_fifo[r_fifo_rd].run_last;
    assign o_m_axis_tuser[0] = r_fifo[r_fifo_rd].stream_done;
    assign o_m_axis_tuser[1] = r_fifo[r_fifo_rd].bad_header;

    // The credit check must keep the queue from overflowing.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !pop |-> r_fifo_cnt < LZD_FIFO_CW'(LZD_FIFO_DEPTH))
        else $error("result queue overflow");

    // A copy in progress always has bytes left to issue.
    a_copy_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_COPY |-> r_cnt != 5'd0)
        else $error("copy state with empty count");

    // The byte that ends a stream also ends the run of its input beat.
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |-> o_m_axis_tlast && !o_m_axis_tuser[1])
        else $error("stream end without run end");

    // After an error beat is issued the parser ignores input until a start.
    a_bad_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_s1_bad |-> $past(n_state == ST_IDLE))
        else $error("parser left idle after a bad header");

endmodule
